>>> design/pdic_pkg.sv
// Shared types, constants and helper functions of the indicator controller.
package pdic_pkg;

  // Animation ring size, the anim counter width that follows from it and the pixel width
  localparam int PIXEL_COUNT = 12;
  localparam int ANIM_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int PIX_W       = 6;

  localparam int CNT_W    = 16;
  localparam int LEVEL_W  = 8;
  localparam int SPEED_W  = 3;
  localparam int DIR_W    = 4;
  localparam int STRIP_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Result item packing in m_tdata, lowest bit first
  localparam int OFS_ACCEPTED   = 0;
  localparam int OFS_SPEED      = 1;
  localparam int OFS_ALERT      = 4;
  localparam int OFS_BUZZER     = 6;
  localparam int OFS_LOAD       = 7;
  localparam int OFS_DIRECTION  = 8;
  localparam int OFS_STRIPS     = 12;
  localparam int OFS_LEAD       = 16;
  localparam int OFS_TRAIL      = 22;
  localparam int OFS_BRIGHTNESS = 28;
  localparam int RES_BITS       = 36;
  localparam int RES_W          = 40;

  // Command prefixes (upper nibble), direction uses the top two bits only
  localparam logic [3:0] PFX_SPEED = 4'hA;
  localparam logic [3:0] PFX_ALERT = 4'hB;
  localparam logic [3:0] PFX_LOAD  = 4'hC;
  localparam logic [1:0] DIR_TOP   = 2'b01;

  localparam logic [SPEED_W-1:0] SPEED_MIN = 3'd1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 3'd5;
  localparam logic [DIR_W-1:0]   DIR_STOP  = 4'd0;
  localparam logic [DIR_W-1:0]   DIR_LAST  = 4'd8;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ALERT_OFF   = 2'd0,
    ALERT_PULSE = 2'd1,
    ALERT_CONT  = 2'd2
  } alert_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_INTERVAL = 3'd0,
    REG_LOAD_TIMEOUT   = 3'd1,
    REG_SLOW_STEP      = 3'd2,
    REG_FAST_STEP      = 3'd3,
    REG_DIM_LEVEL      = 3'd4,
    REG_BRIGHT_LEVEL   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   pulse_interval;
    logic [CNT_W-1:0]   load_timeout;
    logic [CNT_W-1:0]   slow_step;
    logic [CNT_W-1:0]   fast_step;
    logic [LEVEL_W-1:0] dim_level;
    logic [LEVEL_W-1:0] bright_level;
  } cfg_t;

  // Indicator state as it stands after one item
  typedef struct packed {
    logic               accepted;
    logic [SPEED_W-1:0] speed;
    alert_t             alert;
    logic               phase;
    logic               load;
    logic [DIR_W-1:0]   direction;
    logic [ANIM_W-1:0]  anim;
  } ind_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  // lo + (speed-1)*(hi-lo)/4, division truncated toward zero
  function automatic logic [CNT_W-1:0] speed_map(input logic [SPEED_W-1:0] speed,
                                                 input logic [CNT_W-1:0]   lo,
                                                 input logic [CNT_W-1:0]   hi);
    logic signed [CNT_W:0]   d;
    logic signed [SPEED_W:0] sm;
    logic signed [CNT_W+4:0] p;
    logic signed [CNT_W+4:0] q;
    logic signed [CNT_W+4:0] v;
    d  = signed'({1'b0, hi}) - signed'({1'b0, lo});
    sm = signed'({1'b0, speed - SPEED_MIN});
    p  = d * sm;
    q  = p[CNT_W+4] ? ((p + 21'sd3) >>> 2) : (p >>> 2);
    v  = q + signed'({5'b0, lo});
    return v[CNT_W-1:0];
  endfunction

  function automatic logic [STRIP_W-1:0] strip_mask(input logic [DIR_W-1:0] dir);
    logic [STRIP_W-1:0] m;
    case (dir)
      4'd1:    m = 4'h9;
      4'd2:    m = 4'h1;
      4'd3:    m = 4'h3;
      4'd4:    m = 4'h2;
      4'd5:    m = 4'h6;
      4'd6:    m = 4'h4;
      4'd7:    m = 4'hC;
      4'd8:    m = 4'h8;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

>>> design/pdic_cfg.sv
// Configuration register file of the indicator controller.
module pdic_cfg
  import pdic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_interval <= 16'd100;
      cfg.load_timeout   <= 16'd1000;
      cfg.slow_step      <= 16'd180;
      cfg.fast_step      <= 16'd15;
      cfg.dim_level      <= 8'd40;
      cfg.bright_level   <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_INTERVAL: cfg.pulse_interval <= cfg_data;
        REG_LOAD_TIMEOUT:   cfg.load_timeout   <= cfg_data;
        REG_SLOW_STEP:      cfg.slow_step      <= cfg_data;
        REG_FAST_STEP:      cfg.fast_step      <= cfg_data;
        REG_DIM_LEVEL:      cfg.dim_level      <= cfg_data[LEVEL_W-1:0];
        REG_BRIGHT_LEVEL:   cfg.bright_level   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/pdic_state.sv
// Command decode, millisecond timers and indicator state registers.
module pdic_state
  import pdic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  action_t           action,
  input  logic [BYTE_W-1:0] packet_byte,
  input  cfg_t              cfg,
  output ind_state_t        st_next
);

  logic [SPEED_W-1:0] speed;
  alert_t             alert;
  logic               load;
  logic [DIR_W-1:0]   direction;
  logic               phase;
  logic [CNT_W-1:0]   pulse_elapsed;
  logic [CNT_W-1:0]   load_elapsed;
  logic [CNT_W-1:0]   step_elapsed;
  logic [ANIM_W-1:0]  anim;

  logic [CNT_W-1:0] pulse_elapsed_next;
  logic [CNT_W-1:0] load_elapsed_next;
  logic [CNT_W-1:0] step_elapsed_next;
  logic [CNT_W-1:0] step_interval;
  logic [3:0]       nib;

  assign nib = packet_byte[3:0];

  always_comb begin
    st_next.accepted  = 1'b0;
    st_next.speed     = speed;
    st_next.alert     = alert;
    st_next.load      = load;
    st_next.direction = direction;
    st_next.phase     = phase;
    st_next.anim      = anim;
    pulse_elapsed_next = pulse_elapsed;
    load_elapsed_next  = load_elapsed;
    step_elapsed_next  = step_elapsed;

    // decode or advance time
    if (action == ACT_TICK) begin
      pulse_elapsed_next = sat_inc(pulse_elapsed);
      load_elapsed_next  = sat_inc(load_elapsed);
      step_elapsed_next  = sat_inc(step_elapsed);
    end else begin
      case (packet_byte[7:4])
        PFX_SPEED: begin
          if (nib inside {[4'd1:4'd5]}) begin
            st_next.speed    = nib[SPEED_W-1:0];
            st_next.accepted = 1'b1;
          end
        end
        PFX_ALERT: begin
          if (nib inside {[4'd0:4'd2]}) begin
            st_next.alert    = alert_t'(nib[1:0]);
            st_next.accepted = 1'b1;
          end
        end
        PFX_LOAD: begin
          if (nib inside {[4'd0:4'd1]}) begin
            st_next.load      = nib[0];
            load_elapsed_next = '0;
            st_next.accepted  = 1'b1;
          end
        end
        default: begin
          if (packet_byte[7:6] == DIR_TOP && nib <= DIR_LAST) begin
            st_next.direction = nib;
            st_next.accepted  = 1'b1;
          end
        end
      endcase
    end

    // step interval follows the speed as it stands after decode
    step_interval = speed_map(st_next.speed, cfg.slow_step, cfg.fast_step);

    // buzzer pulse phase
    case (st_next.alert)
      ALERT_OFF: st_next.phase = 1'b0;
      ALERT_PULSE: begin
        if (pulse_elapsed_next >= cfg.pulse_interval) begin
          pulse_elapsed_next = '0;
          st_next.phase      = ~phase;
        end
      end
      default: ;
    endcase

    // load timeout
    if (st_next.load && load_elapsed_next > cfg.load_timeout) begin
      st_next.load = 1'b0;
    end

    // animation step
    if (st_next.direction != DIR_STOP && step_elapsed_next >= step_interval) begin
      step_elapsed_next = '0;
      st_next.anim = (anim == ANIM_W'(PIXEL_COUNT - 1)) ? '0 : anim + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed         <= SPEED_MIN;
      alert         <= ALERT_OFF;
      load          <= 1'b0;
      direction     <= DIR_STOP;
      phase         <= 1'b0;
      pulse_elapsed <= '0;
      load_elapsed  <= '0;
      step_elapsed  <= '0;
      anim          <= '0;
    end else if (fire) begin
      speed         <= st_next.speed;
      alert         <= st_next.alert;
      load          <= st_next.load;
      direction     <= st_next.direction;
      phase         <= st_next.phase;
      pulse_elapsed <= pulse_elapsed_next;
      load_elapsed  <= load_elapsed_next;
      step_elapsed  <= step_elapsed_next;
      anim          <= st_next.anim;
    end
  end

endmodule

>>> design/pdic_view.sv
// Maps the indicator state onto the packed result item.
module pdic_view
  import pdic_pkg::*;
(
  input  ind_state_t       st,
  input  cfg_t             cfg,
  output logic [RES_W-1:0] result
);

  logic               buzz;
  logic               reversed;
  logic [PIX_W-1:0]   lead;
  logic [PIX_W-1:0]   trail;
  logic [CNT_W-1:0]   bright_wide;

  always_comb begin
    case (st.alert)
      ALERT_CONT:  buzz = 1'b1;
      ALERT_PULSE: buzz = st.phase;
      default:     buzz = 1'b0;
    endcase
  end

  // mirror the ring for the rearward directions
  assign reversed = st.direction inside {4'd4, 4'd5, 4'd6};
  assign lead     = reversed ? PIX_W'(PIXEL_COUNT - 1) - PIX_W'(st.anim) : PIX_W'(st.anim);
  assign trail    = (lead == PIX_W'(PIXEL_COUNT - 1)) ? '0 : lead + 1'b1;

  assign bright_wide = speed_map(st.speed, CNT_W'(cfg.dim_level), CNT_W'(cfg.bright_level));

  assign result = {(RES_W - RES_BITS)'(0),
                   bright_wide[LEVEL_W-1:0],
                   trail,
                   lead,
                   strip_mask(st.direction),
                   st.direction,
                   st.load,
                   buzz,
                   st.alert,
                   st.speed,
                   st.accepted};

endmodule

>>> design/packet_driven_indicator_controller.sv
// Top level of the packet driven indicator controller.
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  s_tdata: packet_byte, s_tuser: action
//   m_        out        m_tvalid/m_tready  m_tdata: one result item per input item
//   cfg_      in         cfg_we             cfg_index, cfg_data (write only)
//
// An accepted item is held in the input register, then the decode and
// timer update run combinationally into the result register, one item per
// cycle sustained while the m_ side does not stall. Rate is set by the result
// register; a stalled m_ side holds it and the input register, so s_tready
// falls only when both are full. Reset is synchronous and restores every
// state and configuration register.
module packet_driven_indicator_controller
  import pdic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] packet_byte
  input  logic                 s_tuser,   // [0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [0] accepted, [3:1] speed_level, [5:4] alert_mode, [6] buzzer_on,
  // [7] load_led, [11:8] direction, [15:12] active_strips, [21:16] lead_pixel,
  // [27:22] trail_pixel, [35:28] brightness, [39:36] zero
  output logic [RES_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t              cfg;
  ind_state_t        st_next;
  logic [RES_W-1:0]  result;

  // input register
  logic              in_valid;
  action_t           in_action;
  logic [BYTE_W-1:0] in_byte;

  // result register
  logic              out_valid;
  logic [RES_W-1:0]  out_data;

  logic advance;
  logic fire;
  logic take;

  // the result register frees up when empty or drained this cycle
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  pdic_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdic_state u_state (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .action      (in_action),
    .packet_byte (in_byte),
    .cfg         (cfg),
    .st_next     (st_next)
  );

  pdic_view u_view (
    .st     (st_next),
    .cfg    (cfg),
    .result (result)
  );

  // hold the input item until the update stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_action <= action_t'(s_tuser);
      in_byte   <= s_tdata;
    end
  end

  // load a fresh result, drop a delivered one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

>>> design/pdic_checker.sv
// Port-level assertions of the indicator controller, bound to the top level.
module pdic_checker
  import pdic_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [RES_W-1:0] m_tdata
);

  logic [SPEED_W-1:0] speed;
  logic [1:0]         alert;
  logic               buzzer;
  logic [DIR_W-1:0]   dir;
  logic [STRIP_W-1:0] strips;
  logic [PIX_W-1:0]   lead;
  logic [PIX_W-1:0]   trail;

  assign speed  = m_tdata[OFS_SPEED +: SPEED_W];
  assign alert  = m_tdata[OFS_ALERT +: 2];
  assign buzzer = m_tdata[OFS_BUZZER];
  assign dir    = m_tdata[OFS_DIRECTION +: DIR_W];
  assign strips = m_tdata[OFS_STRIPS +: STRIP_W];
  assign lead   = m_tdata[OFS_LEAD +: PIX_W];
  assign trail  = m_tdata[OFS_TRAIL +: PIX_W];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> speed >= SPEED_MIN && speed <= SPEED_MAX)
    else $error("speed level out of range");

  a_buzzer_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (alert == ALERT_CONT && buzzer) || (alert == ALERT_OFF && !buzzer)
                 || alert == ALERT_PULSE)
    else $error("buzzer level disagrees with alert mode");

  a_stop_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (dir == DIR_STOP) == (strips == '0) && dir <= DIR_LAST)
    else $error("strip mask disagrees with direction");

  a_pixel_ring: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> lead < PIX_W'(PIXEL_COUNT) && trail < PIX_W'(PIXEL_COUNT)
                 && (trail == lead + 1'b1 || (trail == '0 && lead == PIX_W'(PIXEL_COUNT - 1))))
    else $error("pixel indices leave the ring");

endmodule

bind packet_driven_indicator_controller pdic_checker u_pdic_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
